FILE: hw/rtl/tss_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and codes for the thread slot scheduler.
// -----------------------------------------------------------------------------
package tss_pkg;

  // Table geometry
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Fixed field widths
  localparam int FUNC_W     = 3;
  localparam int TGT_W      = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int STATUS_W   = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESUME  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_YIELD   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_EXIT    = 3'd4;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_RUNNABLE = 2'd2,
    ST_WAIT     = 2'd3
  } slot_state_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_HALTED  = 2'd3
  } status_e;

  typedef slot_state_e [SLOT_COUNT-1:0] slot_tbl_t;

  // One result transaction
  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] created_slot;
    logic [SLOT_OUT_W-1:0] running_slot;
    logic                  switched;
  } res_t;

  // One request transaction
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TGT_W-1:0]  target_slot;
  } req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tss_find_first.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tss_find_first
// Priority encoder: lowest set bit of a slot mask.
// -----------------------------------------------------------------------------
module tss_find_first
  import tss_pkg::*;
(
  input  logic [SLOT_COUNT-1:0] mask_i,
  output logic                  found_o,
  output logic [SLOT_IDX_W-1:0] idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    // scan down so the lowest hit wins
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (mask_i[i]) begin
        found_o = 1'b1;
        idx_o   = SLOT_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tss_exec.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tss_exec
// Single-pass next-state and result logic for one scheduler request.
// -----------------------------------------------------------------------------
module tss_exec
  import tss_pkg::*;
(
  input  req_t                  req_i,
  input  slot_tbl_t             slot_q_i,
  input  logic [SLOT_IDX_W-1:0] cur_q_i,
  input  logic                  halt_q_i,
  output slot_tbl_t             slot_d_o,
  output logic [SLOT_IDX_W-1:0] cur_d_o,
  output logic                  halt_d_o,
  output res_t                  res_o
);

  logic [SLOT_COUNT-1:0] free_mask;
  logic [SLOT_COUNT-1:0] run_mask;
  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic                  run_found;
  logic [SLOT_IDX_W-1:0] run_idx;
  logic                  tgt_ok;
  logic [SLOT_IDX_W-1:0] tgt_idx;
  logic                  do_pick;
  status_e               status;
  logic [SLOT_IDX_W-1:0] created;
  logic                  sw;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_mask[i] = (slot_q_i[i] == ST_FREE) && (i != 0);
      run_mask[i]  = (slot_q_i[i] == ST_RUNNABLE) && (SLOT_IDX_W'(i) != cur_q_i);
    end
  end

  tss_find_first u_ff_free (
    .mask_i  (free_mask),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  // current slot's own state never affects this mask, so it stays valid
  // after suspend or exit rewrites the current entry
  tss_find_first u_ff_run (
    .mask_i  (run_mask),
    .found_o (run_found),
    .idx_o   (run_idx)
  );

  assign tgt_ok  = (req_i.target_slot != '0) && (32'(req_i.target_slot) < SLOT_COUNT);
  assign tgt_idx = SLOT_IDX_W'(req_i.target_slot);

  always_comb begin
    slot_d_o = slot_q_i;
    cur_d_o  = cur_q_i;
    halt_d_o = halt_q_i;
    status   = STAT_DONE;
    created  = '0;
    sw       = 1'b0;
    do_pick  = 1'b0;

    if (halt_q_i) begin
      status = STAT_HALTED;
    end else begin
      case (req_i.func)
        FUNC_CREATE: begin
          if (free_found) begin
            slot_d_o[free_idx] = ST_RUNNABLE;
            created            = free_idx;
          end else begin
            status = STAT_FULL;
          end
        end
        FUNC_SUSPEND: begin
          if (!tgt_ok || !(slot_q_i[tgt_idx] == ST_RUNNABLE ||
                           slot_q_i[tgt_idx] == ST_RUNNING)) begin
            status = STAT_IGNORED;
          end else begin
            slot_d_o[tgt_idx] = ST_WAIT;
            do_pick           = (tgt_idx == cur_q_i);
          end
        end
        FUNC_RESUME: begin
          if (!tgt_ok || slot_q_i[tgt_idx] != ST_WAIT) begin
            status = STAT_IGNORED;
          end else begin
            slot_d_o[tgt_idx] = ST_RUNNABLE;
          end
        end
        FUNC_YIELD: begin
          do_pick = 1'b1;
        end
        FUNC_EXIT: begin
          slot_d_o[cur_q_i] = ST_FREE;
          do_pick           = 1'b1;
        end
        default: begin
          status = STAT_IGNORED;
        end
      endcase

      if (do_pick) begin
        if (run_found) begin
          if (slot_d_o[cur_q_i] == ST_RUNNING) begin
            slot_d_o[cur_q_i] = ST_RUNNABLE;
          end
          slot_d_o[run_idx] = ST_RUNNING;
          cur_d_o           = run_idx;
          sw                = 1'b1;
        end else if (slot_d_o[cur_q_i] == ST_RUNNING ||
                     slot_d_o[cur_q_i] == ST_RUNNABLE) begin
          slot_d_o[cur_q_i] = ST_RUNNING;
        end else begin
          halt_d_o = 1'b1;
          status   = STAT_HALTED;
        end
      end
    end

    res_o.status       = status;
    res_o.created_slot = SLOT_OUT_W'(created);
    res_o.running_slot = SLOT_OUT_W'(cur_d_o);
    res_o.switched     = sw;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/thread_slot_scheduler.sv
`default_nettype none
// -----------------------------------------------------------------------------
// thread_slot_scheduler
// Priority scheduler over a fixed table of thread slots (lowest runnable wins).
// -----------------------------------------------------------------------------
// Each request transaction carries one operation (create, suspend, resume,
// yield, exit) and returns exactly one result transaction with a status, the
// slot claimed by create, the slot running afterwards and a switch flag.
// Throughput is one transaction per cycle while results are taken. On input
// acceptance the request is loaded into the request register; the result
// register is loaded from it after one pass through the slot-table update
// logic (two 16-way priority encoders plus the table write). A result
// that the receiver has not taken holds the request register, so in_ready
// drops once both registers are full. The slot table, current slot and
// halt flag update on the same edge that loads the result, so back-to-back
// requests always see the state left by the one before. After reset slot 0
// is running and all others are free; once halted, every request answers
// "halted" until the next reset.
// -----------------------------------------------------------------------------
module thread_slot_scheduler
  import tss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [TGT_W-1:0]      target_slot_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_OUT_W-1:0] created_slot_o,
  output logic [SLOT_OUT_W-1:0] running_slot_o,
  output logic                  switched_o
);

  // request register
  logic                  req_vld_q;
  req_t                  req_q;
  // result register
  logic                  res_vld_q;
  res_t                  res_q;
  // scheduler state
  slot_tbl_t             slot_q;
  slot_tbl_t             slot_d;
  logic [SLOT_IDX_W-1:0] cur_q;
  logic [SLOT_IDX_W-1:0] cur_d;
  logic                  halt_q;
  logic                  halt_d;
  res_t                  res_d;

  logic                  exec_fire;
  logic                  in_fire;

  // request executes when the result slot is free or draining this cycle
  assign exec_fire  = req_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || exec_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_fire) begin
      req_vld_q <= 1'b1;
    end else if (exec_fire) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.func        <= func_i;
      req_q.target_slot <= target_slot_i;
    end
  end

  tss_exec u_exec (
    .req_i    (req_q),
    .slot_q_i (slot_q),
    .cur_q_i  (cur_q),
    .halt_q_i (halt_q),
    .slot_d_o (slot_d),
    .cur_d_o  (cur_d),
    .halt_d_o (halt_d),
    .res_o    (res_d)
  );

  // scheduler state: slot 0 running, rest free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_q[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
      end
      cur_q  <= '0;
      halt_q <= 1'b0;
    end else if (exec_fire) begin
      slot_q <= slot_d;
      cur_q  <= cur_d;
      halt_q <= halt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (exec_fire) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign status_o       = res_q.status;
  assign created_slot_o = res_q.created_slot;
  assign running_slot_o = res_q.running_slot;
  assign switched_o     = res_q.switched;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  // while live, the current slot is the running thread
  a_cur_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !halt_q |-> (slot_q[cur_q] == ST_RUNNING))
    else $error("current slot not in running state");

  // a switch or a claimed slot only comes with a completed operation
  a_switch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && (res_q.switched || res_q.created_slot != '0)) |->
      (res_q.status == STAT_DONE))
    else $error("switch or create reported with non-done status");

  // the state only moves when a request executes
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> ($stable(slot_q) && $stable(cur_q)))
    else $error("scheduler state changed without a request");

endmodule

`default_nettype wire
